### rtl/core/pose_dec_pkg.sv
// Package for the pose anchor decoder: sizes, codes, stream payload layouts
// and the sigmoid table, which is built at elaboration.
// No dependencies.
package pose_dec_pkg;

   localparam int NUM_KPTS          = 17;
   localparam int GRID_MAX          = 128;
   localparam int SIG_LUT_DEPTH     = 1024;

   localparam int LUT_BITS          = $clog2(SIG_LUT_DEPTH);
   localparam int ANCHOR_BITS       = $clog2(GRID_MAX) + 1;
   localparam int KPT_CNT_BITS      = $clog2(NUM_KPTS + 1);

   localparam int REQ_DATA_BITS     = 144;
   localparam int RSP_DATA_BITS     = 152;
   localparam int CSR_ADDR_BITS     = 5;
   localparam int CSR_DATA_BITS     = 32;

   localparam longint EXP_STEP_Q31  = 64'd2139111403;

   typedef enum logic {
      CMD_HEADER   = 1'b0,
      CMD_KEYPOINT = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_BOX      = 1'b0,
      KIND_KEYPOINT = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      REG_SCORE_THRESHOLD = 3'd0,
      REG_SCALE_RECIP     = 3'd1,
      REG_PAD_X           = 3'd2,
      REG_PAD_Y           = 3'd3,
      REG_FRAME_WIDTH     = 3'd4,
      REG_FRAME_HEIGHT    = 3'd5,
      REG_ROI_X           = 3'd6,
      REG_ROI_Y           = 3'd7
   } csr_index_type;

   // Packed structs list their first field last, so it lands in the low bits.
   typedef struct packed {
      logic signed [15:0] kpt_vis_logit;
      logic signed [15:0] kpt_dy;
      logic signed [15:0] kpt_dx;
      logic signed [15:0] dist_bottom;
      logic signed [15:0] dist_right;
      logic signed [15:0] dist_top;
      logic signed [15:0] dist_left;
      logic signed [15:0] class_logit;
      logic [1:0]         level;
      logic [6:0]         grid_y;
      logic [6:0]         grid_x;
   } req_data_type;

   typedef struct packed {
      logic [4:0]         fill;
      logic [15:0]        kpt_visibility;
      logic signed [18:0] kpt_y;
      logic signed [18:0] kpt_x;
      logic [4:0]         kpt_index;
      logic [15:0]        score;
      logic [17:0]        box_y2;
      logic [17:0]        box_x2;
      logic [17:0]        box_y1;
      logic [17:0]        box_x1;
   } rsp_data_type;

   typedef logic [15:0] sig_lut_type [SIG_LUT_DEPTH];

   // Q1.31 product, rounded half up.
   function automatic logic [63:0] qmul31(input logic [63:0] a, input logic [63:0] b);
      return (a * b + 64'h4000_0000) >> 31;
   endfunction

   // e^(-k/256) in Q1.31 by square and multiply.
   function automatic logic [63:0] exp_neg_q31(input logic [11:0] k);
      logic [63:0] r;
      logic [63:0] base;
      r    = 64'h8000_0000;
      base = EXP_STEP_Q31;
      for (int i = 0; i < 12; i++) begin
         if (k[i]) r = qmul31(r, base);
         base = qmul31(base, base);
      end
      return r;
   endfunction

   // Restoring division, used only while the table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [15:0] sigmoid_exact(input int l);
      logic [11:0] mag;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] s;
      mag = 12'((l < 0) ? -l : l);
      e   = exp_neg_q31(mag);
      den = 64'h8000_0000 + e;
      num = (l < 0) ? (e << 16) : (64'd1 << 47);
      s   = udiv64(num + (den >> 1), den);
      return (s > 64'd65535) ? 16'hFFFF : s[15:0];
   endfunction

   // Entry i holds the sigmoid at the center of its logit bucket.
   function automatic sig_lut_type sig_lut_build();
      sig_lut_type t;
      int          l;
      for (int i = 0; i < SIG_LUT_DEPTH; i++) begin
         l    = ((2 * i + 1) * 4096) / (2 * SIG_LUT_DEPTH) - 2048;
         t[i] = sigmoid_exact(l);
      end
      return t;
   endfunction

   localparam sig_lut_type SIG_LUT = sig_lut_build();

   localparam int KPT_COORD_MAX = 262143;
   localparam int KPT_COORD_MIN = -262144;

endpackage

### rtl/core/pose_anchor_decoder_top.sv
// An accepted item is held in the input register; its result is registered in the
// result register that drives rsp_tvalid. One item per cycle unless the output stalls.
// The cycle is bounded by the sigmoid table read and the four 24 x 25 bit letterbox
// multipliers that work side by side between the input and result registers.
// Reset (synchronous): both stages empty, no cell open, registers at their defaults.
// Depends on pose_dec_pkg.
module pose_anchor_decoder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input stream.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // grid_x, grid_y, level, class_logit, dist_left, dist_top, dist_right,
   // dist_bottom, kpt_dx, kpt_dy, kpt_vis_logit
   input  logic [pose_dec_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic                                   req_tuser,
   // Result stream.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // box_x1, box_y1, box_x2, box_y2, score, kpt_index, kpt_x, kpt_y,
   // kpt_visibility, zero fill
   output logic [pose_dec_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // out_kind
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   // Register port.
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [pose_dec_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [pose_dec_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [pose_dec_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);

   // Configuration registers.
   logic [15:0] score_threshold_ff;
   logic [23:0] scale_recip_ff;
   logic [13:0] pad_x_ff;
   logic [13:0] pad_y_ff;
   logic [13:0] frame_width_ff;
   logic [13:0] frame_height_ff;
   logic [12:0] roi_x_ff;
   logic [12:0] roi_y_ff;

   logic                      csr_write;
   pose_dec_pkg::csr_index_type csr_index;

   // Cell state.
   logic                                  cell_passed_ff;
   logic [pose_dec_pkg::KPT_CNT_BITS-1:0] kpt_count_ff;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0]  anchor_x_half_ff;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0]  anchor_y_half_ff;
   logic [1:0]                            stride_level_ff;

   logic                                  cell_passed_in;
   logic [pose_dec_pkg::KPT_CNT_BITS-1:0] kpt_count_in;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0]  anchor_x_half_in;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0]  anchor_y_half_in;
   logic [1:0]                            stride_level_in;

   // Input stage.
   logic                       s1_valid_ff;
   pose_dec_pkg::req_data_type s1_data_ff;
   pose_dec_pkg::cmd_type      s1_cmd_ff;

   // Result stage.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   pose_dec_pkg::rsp_data_type rsp_data_ff;
   pose_dec_pkg::rsp_data_type rsp_data_in;
   pose_dec_pkg::kind_type     rsp_kind_ff;
   pose_dec_pkg::kind_type     rsp_kind_in;
   logic                       rsp_last_ff;
   logic                       rsp_last_in;

   // Stage 1 datapath.
   logic                                 hdr;
   logic                                 s1_fire;
   logic                                 has_result;
   logic                                 pass;
   logic                                 kpt_open;
   logic [8:0]                           gx_sat;
   logic [8:0]                           gy_sat;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0] hdr_anchor_x;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0] hdr_anchor_y;
   logic [1:0]                           hdr_level;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0] ax;
   logic [pose_dec_pkg::ANCHOR_BITS-1:0] ay;
   logic [1:0]                           lvl;
   logic signed [17:0]                   base_x;
   logic signed [17:0]                   base_y;
   logic signed [17:0]                   g0;
   logic signed [17:0]                   g1;
   logic signed [17:0]                   g2;
   logic signed [17:0]                   g3;
   logic signed [27:0]                   f0;
   logic signed [27:0]                   f1;
   logic signed [27:0]                   f2;
   logic signed [27:0]                   f3;
   logic [15:0]                          sig;

   function automatic logic [15:0] sig_lookup(input logic signed [15:0] l);
      logic signed [15:0] c;
      logic [11:0]        u;
      logic [23:0]        scaled;
      if (l < -16'sd2048)      c = -16'sd2048;
      else if (l > 16'sd2047)  c = 16'sd2047;
      else                     c = l;
      u      = 12'(c + 16'sd2048);
      scaled = 24'(u) * 24'(pose_dec_pkg::SIG_LUT_DEPTH);
      return pose_dec_pkg::SIG_LUT[scaled[pose_dec_pkg::LUT_BITS+11:12]];
   endfunction

   // Grid-unit Q8.8 coordinate to frame pixels Q.4, letterbox undone.
   // The shift right by 20 after adding half rounds half toward plus infinity.
   function automatic logic signed [27:0] frame_coord(input logic signed [17:0] g,
                                                      input logic [1:0]         lv,
                                                      input logic [13:0]        pad,
                                                      input logic [23:0]        recip);
      logic signed [22:0] m;
      logic signed [23:0] d;
      logic signed [47:0] p;
      case (lv)
         2'd0:    m = 23'(g) <<< 3;
         2'd1:    m = 23'(g) <<< 4;
         default: m = 23'(g) <<< 5;
      endcase
      d = 24'(m) - $signed(24'({pad, 4'b0000}));
      p = d * $signed({1'b0, recip});
      p = p + 48'sd524288;
      return 28'(p >>> 20);
   endfunction

   function automatic logic [17:0] box_edge(input logic signed [27:0] v,
                                            input logic [13:0]        frame,
                                            input logic [12:0]        roi);
      logic signed [27:0] hi;
      logic [17:0]        c;
      logic [18:0]        s;
      hi = $signed(28'({frame, 4'b0000}));
      if (v > hi)      c = hi[17:0];
      else if (v < 0)  c = '0;
      else             c = v[17:0];
      s = {1'b0, c} + 19'({roi, 4'b0000});
      return s[18] ? 18'h3FFFF : s[17:0];
   endfunction

   function automatic logic signed [18:0] kpt_coord(input logic signed [27:0] v,
                                                    input logic [12:0]        roi);
      logic signed [28:0] s;
      s = 29'(v) + $signed(29'({roi, 4'b0000}));
      if (s > 29'(pose_dec_pkg::KPT_COORD_MAX))      s = 29'(pose_dec_pkg::KPT_COORD_MAX);
      else if (s < 29'(pose_dec_pkg::KPT_COORD_MIN)) s = 29'(pose_dec_pkg::KPT_COORD_MIN);
      return s[18:0];
   endfunction

   // ---------------------------------------------------------------- registers port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = pose_dec_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         score_threshold_ff <= 16'd16384;
         scale_recip_ff     <= 24'd65536;
         pad_x_ff           <= '0;
         pad_y_ff           <= '0;
         frame_width_ff     <= 14'd640;
         frame_height_ff    <= 14'd640;
         roi_x_ff           <= '0;
         roi_y_ff           <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pose_dec_pkg::REG_SCORE_THRESHOLD: score_threshold_ff <= csr_pwdata[15:0];
            pose_dec_pkg::REG_SCALE_RECIP:     scale_recip_ff     <= csr_pwdata[23:0];
            pose_dec_pkg::REG_PAD_X:           pad_x_ff           <= csr_pwdata[13:0];
            pose_dec_pkg::REG_PAD_Y:           pad_y_ff           <= csr_pwdata[13:0];
            pose_dec_pkg::REG_FRAME_WIDTH:     frame_width_ff     <= csr_pwdata[13:0];
            pose_dec_pkg::REG_FRAME_HEIGHT:    frame_height_ff    <= csr_pwdata[13:0];
            pose_dec_pkg::REG_ROI_X:           roi_x_ff           <= csr_pwdata[12:0];
            pose_dec_pkg::REG_ROI_Y:           roi_y_ff           <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pose_dec_pkg::REG_SCORE_THRESHOLD: csr_prdata = 32'(score_threshold_ff);
         pose_dec_pkg::REG_SCALE_RECIP:     csr_prdata = 32'(scale_recip_ff);
         pose_dec_pkg::REG_PAD_X:           csr_prdata = 32'(pad_x_ff);
         pose_dec_pkg::REG_PAD_Y:           csr_prdata = 32'(pad_y_ff);
         pose_dec_pkg::REG_FRAME_WIDTH:     csr_prdata = 32'(frame_width_ff);
         pose_dec_pkg::REG_FRAME_HEIGHT:    csr_prdata = 32'(frame_height_ff);
         pose_dec_pkg::REG_ROI_X:           csr_prdata = 32'(roi_x_ff);
         pose_dec_pkg::REG_ROI_Y:           csr_prdata = 32'(roi_y_ff);
         default:                           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- input stage
   // An item that yields no result leaves stage 1 even while the output stalls.
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= pose_dec_pkg::req_data_type'(req_tdata);
         s1_cmd_ff  <= pose_dec_pkg::cmd_type'(req_tuser);
      end
   end

   // ---------------------------------------------------------------- decode
   always_comb begin
      hdr = (s1_cmd_ff == pose_dec_pkg::CMD_HEADER);

      gx_sat = ({2'b00, s1_data_ff.grid_x} > 9'(pose_dec_pkg::GRID_MAX - 1)) ?
               9'(pose_dec_pkg::GRID_MAX - 1) : {2'b00, s1_data_ff.grid_x};
      gy_sat = ({2'b00, s1_data_ff.grid_y} > 9'(pose_dec_pkg::GRID_MAX - 1)) ?
               9'(pose_dec_pkg::GRID_MAX - 1) : {2'b00, s1_data_ff.grid_y};
      hdr_anchor_x = pose_dec_pkg::ANCHOR_BITS'({gx_sat, 1'b1});
      hdr_anchor_y = pose_dec_pkg::ANCHOR_BITS'({gy_sat, 1'b1});
      // Level three decodes like level two.
      hdr_level    = (s1_data_ff.level == 2'd3) ? 2'd2 : s1_data_ff.level;

      ax  = hdr ? hdr_anchor_x : anchor_x_half_ff;
      ay  = hdr ? hdr_anchor_y : anchor_y_half_ff;
      lvl = hdr ? hdr_level    : stride_level_ff;

      base_x = $signed(18'({ax, 7'b0000000}));
      base_y = $signed(18'({ay, 7'b0000000}));

      // Lanes 0 and 1 serve the box's near edges or the keypoint; 2 and 3 the far edges.
      g0 = hdr ? base_x - 18'(s1_data_ff.dist_left) : base_x + 18'(s1_data_ff.kpt_dx);
      g1 = hdr ? base_y - 18'(s1_data_ff.dist_top)  : base_y + 18'(s1_data_ff.kpt_dy);
      g2 = base_x + 18'(s1_data_ff.dist_right);
      g3 = base_y + 18'(s1_data_ff.dist_bottom);

      f0 = frame_coord(g0, lvl, pad_x_ff, scale_recip_ff);
      f1 = frame_coord(g1, lvl, pad_y_ff, scale_recip_ff);
      f2 = frame_coord(g2, lvl, pad_x_ff, scale_recip_ff);
      f3 = frame_coord(g3, lvl, pad_y_ff, scale_recip_ff);

      sig = sig_lookup(hdr ? s1_data_ff.class_logit : s1_data_ff.kpt_vis_logit);

      pass     = (sig >= score_threshold_ff);
      kpt_open = (kpt_count_ff < pose_dec_pkg::KPT_CNT_BITS'(pose_dec_pkg::NUM_KPTS));
      has_result = hdr ? pass : (kpt_open && cell_passed_ff);
      s1_fire  = s1_valid_ff && (!has_result || !rsp_valid_ff || rsp_tready);

      rsp_data_in = '0;
      rsp_last_in = 1'b0;
      if (hdr) begin
         rsp_kind_in        = pose_dec_pkg::KIND_BOX;
         rsp_data_in.box_x1 = box_edge(f0, frame_width_ff,  roi_x_ff);
         rsp_data_in.box_y1 = box_edge(f1, frame_height_ff, roi_y_ff);
         rsp_data_in.box_x2 = box_edge(f2, frame_width_ff,  roi_x_ff);
         rsp_data_in.box_y2 = box_edge(f3, frame_height_ff, roi_y_ff);
         rsp_data_in.score  = sig;
      end else begin
         rsp_kind_in                = pose_dec_pkg::KIND_KEYPOINT;
         rsp_data_in.kpt_index      = 5'(kpt_count_ff);
         rsp_data_in.kpt_x          = kpt_coord(f0, roi_x_ff);
         rsp_data_in.kpt_y          = kpt_coord(f1, roi_y_ff);
         rsp_data_in.kpt_visibility = sig;
         rsp_last_in = (kpt_count_ff ==
                        pose_dec_pkg::KPT_CNT_BITS'(pose_dec_pkg::NUM_KPTS - 1));
      end

      // Cell state moves only when the item in stage 1 leaves it.
      cell_passed_in   = cell_passed_ff;
      kpt_count_in     = kpt_count_ff;
      anchor_x_half_in = anchor_x_half_ff;
      anchor_y_half_in = anchor_y_half_ff;
      stride_level_in  = stride_level_ff;
      if (s1_fire) begin
         if (hdr) begin
            cell_passed_in   = pass;
            kpt_count_in     = '0;
            anchor_x_half_in = hdr_anchor_x;
            anchor_y_half_in = hdr_anchor_y;
            stride_level_in  = hdr_level;
         end else if (kpt_open) begin
            kpt_count_in = kpt_count_ff + 1'b1;
         end
      end

      if (s1_fire && has_result) rsp_valid_in = 1'b1;
      else if (rsp_tready)       rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_passed_ff   <= 1'b0;
         kpt_count_ff     <= pose_dec_pkg::KPT_CNT_BITS'(pose_dec_pkg::NUM_KPTS);
         anchor_x_half_ff <= '0;
         anchor_y_half_ff <= '0;
         stride_level_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cell_passed_ff   <= cell_passed_in;
         kpt_count_ff     <= kpt_count_in;
         anchor_x_half_ff <= anchor_x_half_in;
         anchor_y_half_ff <= anchor_y_half_in;
         stride_level_ff  <= stride_level_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_result) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      kpt_count_ff <= pose_dec_pkg::KPT_CNT_BITS'(pose_dec_pkg::NUM_KPTS))
      else $error("keypoint count ran past the keypoints of a cell");

   a_header_opens_cell: assert property (@(posedge clock) disable iff (reset)
      s1_fire && hdr |=> kpt_count_ff == '0)
      else $error("header left stage 1 without opening a cell");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |-> rsp_valid_ff && !rsp_tready)
      else $error("stage 1 held an item although the result stage was free");

   a_last_on_final_kpt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         rsp_kind_ff == pose_dec_pkg::KIND_KEYPOINT &&
         rsp_data_ff.kpt_index == 5'(pose_dec_pkg::NUM_KPTS - 1))
      else $error("last set on a result that is not the final keypoint");

   a_box_has_score_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == pose_dec_pkg::KIND_BOX |->
         rsp_data_ff.score >= score_threshold_ff)
      else $error("box result with a score below the threshold");

endmodule

### test/tb.sv
// Testbench for pose_anchor_decoder_top: random and directed cells and keypoints go in on the
// req stream, and every rsp transaction is checked against a predictor that runs in the bench.
// Depends on pose_dec_pkg and the block itself.
`timescale 1ns / 1ps

module tb;

   typedef struct {
      pose_dec_pkg::kind_type     kind;
      pose_dec_pkg::rsp_data_type data;
      logic                       last;
   } decode_result_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_tvalid;
   logic                                   req_tready;
   logic [pose_dec_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                                   req_tuser;
   logic                                   rsp_tvalid;
   logic                                   rsp_tready;
   logic [pose_dec_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                                   rsp_tuser;
   logic                                   rsp_tlast;
   logic                                   csr_psel;
   logic                                   csr_penable;
   logic                                   csr_pwrite;
   logic [pose_dec_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [pose_dec_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [pose_dec_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                                   csr_pready;

   // Register copies, at their reset values.
   logic [15:0] cfg_threshold = 16'd16384;
   logic [23:0] cfg_recip     = 24'd65536;
   logic [13:0] cfg_pad_x     = '0;
   logic [13:0] cfg_pad_y     = '0;
   logic [13:0] cfg_width     = 14'd640;
   logic [13:0] cfg_height    = 14'd640;
   logic [12:0] cfg_roi_x     = '0;
   logic [12:0] cfg_roi_y     = '0;

   // Cell state of the predictor.
   logic       cell_pass  = 1'b0;
   logic [4:0] kpts_seen  = 5'(pose_dec_pkg::NUM_KPTS);
   logic [7:0] anchor_x2  = '0;
   logic [7:0] anchor_y2  = '0;
   logic [1:0] stride_sel = '0;

   logic [15:0]       sig_table [pose_dec_pkg::SIG_LUT_DEPTH];
   decode_result_type expected_decodes [$];
   int                mismatches    = 0;
   int                req_gap_pct   = 20;
   int                rsp_stall_pct = 20;
   int                rsp_hold_left = 0;

   pose_anchor_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // Logistic of a Q8.8 logit in Q0.16; e^-x is built from powers of e^(-1/256) in Q1.31.
   function automatic logic [15:0] sigmoid_q16(int l);
      longint unsigned e, step, num, den, q;
      int unsigned     k;
      e    = 64'd1 << 31;
      step = 64'd2139111403;
      k    = (l < 0) ? -l : l;
      while (k != 0) begin
         if ((k & 1) != 0) e = (e * step + (64'd1 << 30)) >> 31;
         step = (step * step + (64'd1 << 30)) >> 31;
         k    = k >> 1;
      end
      den = (64'd1 << 31) + e;
      num = (l < 0) ? (e << 16) : (64'd1 << 47);
      q   = (num + den / 2) / den;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   initial begin
      for (int i = 0; i < pose_dec_pkg::SIG_LUT_DEPTH; i++)
         sig_table[i] = sigmoid_q16(((2 * i + 1) * 4096) / (2 * pose_dec_pkg::SIG_LUT_DEPTH)
                                    - 2048);
   end

   function automatic logic [15:0] sig_lookup(logic signed [15:0] logit);
      int l;
      l = logit;
      if (l < -2048) l = -2048;
      if (l > 2047) l = 2047;
      return sig_table[((l + 2048) * pose_dec_pkg::SIG_LUT_DEPTH) >> 12];
   endfunction

   // Grid units Q8.8 to frame pixels Q.4: scale by stride, remove the pad, multiply by 1/r.
   function automatic longint to_frame_q4(longint g, logic [13:0] pad);
      longint d;
      d = g * (longint'(8) << stride_sel) - (longint'(pad) << 4);
      return (d * longint'(cfg_recip) + (longint'(1) << 19)) >>> 20;
   endfunction

   function automatic logic [17:0] box_edge(longint g, logic [13:0] pad, logic [13:0] frame,
                                            logic [12:0] roi);
      longint v;
      v = to_frame_q4(g, pad);
      if (v > (longint'(frame) << 4)) v = longint'(frame) << 4;
      if (v < 0) v = 0;
      v = v + (longint'(roi) << 4);
      if (v > 262143) v = 262143;
      return v[17:0];
   endfunction

   function automatic logic [18:0] kpt_coord(longint g, logic [13:0] pad, logic [12:0] roi);
      longint v;
      v = to_frame_q4(g, pad) + (longint'(roi) << 4);
      if (v > pose_dec_pkg::KPT_COORD_MAX) v = pose_dec_pkg::KPT_COORD_MAX;
      if (v < pose_dec_pkg::KPT_COORD_MIN) v = pose_dec_pkg::KPT_COORD_MIN;
      return v[18:0];
   endfunction

   function automatic void decode_item(pose_dec_pkg::cmd_type cmd,
                                       pose_dec_pkg::req_data_type d);
      decode_result_type r;
      logic [15:0]       sc;
      logic [4:0]        k;
      longint            ax, ay;
      r.data = '0;
      r.last = 1'b0;
      if (cmd == pose_dec_pkg::CMD_HEADER) begin
         anchor_x2  = 8'(2 * d.grid_x + 1);
         anchor_y2  = 8'(2 * d.grid_y + 1);
         stride_sel = (d.level == 2'd3) ? 2'd2 : d.level;
         kpts_seen  = '0;
         sc         = sig_lookup(d.class_logit);
         cell_pass  = (sc >= cfg_threshold);
         if (!cell_pass) return;
         ax = longint'(anchor_x2) * 128;
         ay = longint'(anchor_y2) * 128;
         r.kind        = pose_dec_pkg::KIND_BOX;
         r.data.box_x1 = box_edge(ax - longint'($signed(d.dist_left)), cfg_pad_x, cfg_width,
                                  cfg_roi_x);
         r.data.box_y1 = box_edge(ay - longint'($signed(d.dist_top)), cfg_pad_y, cfg_height,
                                  cfg_roi_y);
         r.data.box_x2 = box_edge(ax + longint'($signed(d.dist_right)), cfg_pad_x, cfg_width,
                                  cfg_roi_x);
         r.data.box_y2 = box_edge(ay + longint'($signed(d.dist_bottom)), cfg_pad_y,
                                  cfg_height, cfg_roi_y);
         r.data.score  = sc;
         expected_decodes.insert(expected_decodes.size(), r);
      end else begin
         // A keypoint with no cell open is dropped; one of a failed cell is only counted.
         if (kpts_seen >= pose_dec_pkg::NUM_KPTS) return;
         k         = kpts_seen;
         kpts_seen = 5'(kpts_seen + 1);
         if (!cell_pass) return;
         r.kind                = pose_dec_pkg::KIND_KEYPOINT;
         r.data.kpt_index      = k;
         r.data.kpt_x          = kpt_coord(longint'(anchor_x2) * 128
                                           + longint'($signed(d.kpt_dx)), cfg_pad_x, cfg_roi_x);
         r.data.kpt_y          = kpt_coord(longint'(anchor_y2) * 128
                                           + longint'($signed(d.kpt_dy)), cfg_pad_y, cfg_roi_y);
         r.data.kpt_visibility = sig_lookup(d.kpt_vis_logit);
         r.last                = (k == pose_dec_pkg::NUM_KPTS - 1);
         expected_decodes.insert(expected_decodes.size(), r);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      decode_result_type          want;
      pose_dec_pkg::rsp_data_type got;
      if (!reset) begin
         // The prediction goes first, so a result that came too early still finds it.
         if (req_tvalid && req_tready)
            decode_item(pose_dec_pkg::cmd_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decodes.size() == 0) begin
               $error("rsp transaction with no result expected");
               mismatches++;
            end else begin
               want = expected_decodes.pop_front();
               got  = rsp_tdata;
               check_field("out_kind", want.kind, rsp_tuser);
               check_field("box_x1", want.data.box_x1, got.box_x1);
               check_field("box_y1", want.data.box_y1, got.box_y1);
               check_field("box_x2", want.data.box_x2, got.box_x2);
               check_field("box_y2", want.data.box_y2, got.box_y2);
               check_field("score", want.data.score, got.score);
               check_field("kpt_index", want.data.kpt_index, got.kpt_index);
               check_field("kpt_x", want.data.kpt_x, got.kpt_x);
               check_field("kpt_y", want.data.kpt_y, got.kpt_y);
               check_field("kpt_visibility", want.data.kpt_visibility, got.kpt_visibility);
               check_field("zero fill", want.data.fill, got.fill);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(99) < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin : rsp_receiver
      int stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            stall = idle_len(rsp_stall_pct);
            rsp_tready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   // Called and left at a falling edge; the transaction is taken at a rising edge in between.
   task automatic send_item(input pose_dec_pkg::cmd_type cmd,
                            input pose_dec_pkg::req_data_type d);
      int gap;
      gap = idle_len(req_gap_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
   endtask

   // Fields that the command does not use are filled with noise.
   task automatic send_header(input logic [6:0] gx, input logic [6:0] gy, input logic [1:0] lvl,
                              input logic [15:0] logit, input logic [15:0] dl,
                              input logic [15:0] dt, input logic [15:0] dr,
                              input logic [15:0] db);
      logic [159:0]               noise;
      pose_dec_pkg::req_data_type d;
      noise         = {$urandom, $urandom, $urandom, $urandom, $urandom};
      d             = noise[pose_dec_pkg::REQ_DATA_BITS-1:0];
      d.grid_x      = gx;
      d.grid_y      = gy;
      d.level       = lvl;
      d.class_logit = logit;
      d.dist_left   = dl;
      d.dist_top    = dt;
      d.dist_right  = dr;
      d.dist_bottom = db;
      send_item(pose_dec_pkg::CMD_HEADER, d);
   endtask

   task automatic send_keypoint(input logic [15:0] dx, input logic [15:0] dy,
                                input logic [15:0] vis);
      logic [159:0]               noise;
      pose_dec_pkg::req_data_type d;
      noise           = {$urandom, $urandom, $urandom, $urandom, $urandom};
      d               = noise[pose_dec_pkg::REQ_DATA_BITS-1:0];
      d.kpt_dx        = dx;
      d.kpt_dy        = dy;
      d.kpt_vis_logit = vis;
      send_item(pose_dec_pkg::CMD_KEYPOINT, d);
   endtask

   function automatic logic [15:0] rand_q88();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         1:       return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
         2, 3, 4: return 16'($urandom);
         default: return 16'(int'($urandom_range(8191)) - 4096);
      endcase
   endfunction

   function automatic logic [6:0] rand_grid();
      if ($urandom_range(9) == 0) return $urandom_range(1) ? 7'd127 : 7'd0;
      return 7'($urandom_range(127));
   endfunction

   // Stops the stream and waits until every result has arrived and the pipeline is quiet.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write, then a read back of the same register.
   task automatic csr_write(input pose_dec_pkg::csr_index_type idx, input logic [31:0] value);
      logic [31:0] want;
      case (idx)
         pose_dec_pkg::REG_SCORE_THRESHOLD: begin
            want = value & 32'hFFFF;
            cfg_threshold = want[15:0];
         end
         pose_dec_pkg::REG_SCALE_RECIP: begin
            want = value & 32'hFF_FFFF;
            cfg_recip = want[23:0];
         end
         pose_dec_pkg::REG_PAD_X: begin
            want = value & 32'h3FFF;
            cfg_pad_x = want[13:0];
         end
         pose_dec_pkg::REG_PAD_Y: begin
            want = value & 32'h3FFF;
            cfg_pad_y = want[13:0];
         end
         pose_dec_pkg::REG_FRAME_WIDTH: begin
            want = value & 32'h3FFF;
            cfg_width = want[13:0];
         end
         pose_dec_pkg::REG_FRAME_HEIGHT: begin
            want = value & 32'h3FFF;
            cfg_height = want[13:0];
         end
         pose_dec_pkg::REG_ROI_X: begin
            want = value & 32'h1FFF;
            cfg_roi_x = want[12:0];
         end
         default: begin
            want = value & 32'h1FFF;
            cfg_roi_y = want[12:0];
         end
      endcase
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      check_field("csr readback", want, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] thr, input logic [31:0] recip,
                                input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] fw, input logic [31:0] fh,
                                input logic [31:0] rx, input logic [31:0] ry);
      drain_results();
      csr_write(pose_dec_pkg::REG_SCORE_THRESHOLD, thr);
      csr_write(pose_dec_pkg::REG_SCALE_RECIP, recip);
      csr_write(pose_dec_pkg::REG_PAD_X, px);
      csr_write(pose_dec_pkg::REG_PAD_Y, py);
      csr_write(pose_dec_pkg::REG_FRAME_WIDTH, fw);
      csr_write(pose_dec_pkg::REG_FRAME_HEIGHT, fh);
      csr_write(pose_dec_pkg::REG_ROI_X, rx);
      csr_write(pose_dec_pkg::REG_ROI_Y, ry);
   endtask

   // Mostly whole cells; some are cut short, overrun, or keypoints come with no header.
   task automatic run_cells(input int n);
      int done_cnt, pick, nk, extra;
      done_cnt = 0;
      while (done_cnt < n) begin
         pick = $urandom_range(99);
         if (pick < 94) begin
            send_header(rand_grid(), rand_grid(), 2'($urandom_range(3)),
                        ($urandom_range(4) == 0) ? rand_q88() :
                                                   16'(int'($urandom_range(4095)) - 2048),
                        rand_q88(), rand_q88(), rand_q88(), rand_q88());
            nk    = (pick >= 80 && pick < 88) ? $urandom_range(pose_dec_pkg::NUM_KPTS - 1)
                                              : pose_dec_pkg::NUM_KPTS;
            extra = (pick >= 88) ? $urandom_range(1, 3) : 0;
            repeat (nk) send_keypoint(rand_q88(), rand_q88(), rand_q88());
            repeat (extra) send_keypoint(rand_q88(), rand_q88(), rand_q88());
            done_cnt += 1 + nk;
         end else begin
            repeat ($urandom_range(1, 3)) send_keypoint(rand_q88(), rand_q88(), rand_q88());
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      // Last column, level 3 taken as stride 32, saturated logit and distances.
      send_header(7'd127, 7'd0, 2'd3, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_keypoint(16'h7FFF, 16'h8000, 16'h7FFF);
      send_keypoint(16'h8000, 16'h7FFF, 16'h8000);
      repeat (pose_dec_pkg::NUM_KPTS - 2) send_keypoint(rand_q88(), rand_q88(), rand_q88());
      // The cell is complete, so this keypoint has no cell to go to.
      send_keypoint(16'h1234, 16'h0100, 16'h0000);
      // A failed cell still consumes its keypoints.
      send_header(7'd0, 7'd127, 2'd0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_keypoint(16'h0080, 16'hFF80, 16'h0400);
      // A level 1 cell abandoned by the next header.
      send_header(7'd64, 7'd64, 2'd1, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
      send_keypoint(16'h0000, 16'h0000, 16'h0000);
      send_header(7'd1, 7'd2, 2'd2, 16'h0800, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF);
      send_keypoint(16'hFFFF, 16'h0001, 16'hF800);
   endtask

   task automatic test_config_sweep();
      req_gap_pct   = 25;
      rsp_stall_pct = 25;
      // Everything passes; large scale and region offsets drive the outputs into saturation.
      apply_setting(0, 24'hFF_FFFF, 0, 0, 14'h3FFF, 14'h3FFF, 13'h1FFF, 13'h1FFF);
      run_cells(150);
      // No score can reach the top threshold, so no result at all.
      apply_setting(16'hFFFF, 0, 14'h3FFF, 14'h3FFF, 0, 0, 0, 0);
      run_cells(40);
      // Zero frame width pins every x edge of the box to the region offset.
      apply_setting(0, 24'h00_C000, 14'h3FFF, 0, 0, 8192, 0, 8191);
      run_cells(100);
      apply_setting(16'h8000, 65536, 0, 0, 640, 640, 0, 0);
      run_cells(150);
      for (int i = 0; i < 6; i++) begin
         req_gap_pct   = (i == 1 || i == 3) ? 0 : 25;
         rsp_stall_pct = (i == 1 || i == 4) ? 0 : 25;
         apply_setting($urandom_range(45000),
                       ($urandom_range(3) == 0) ? $urandom_range(24'hFF_FFFF)
                                                : $urandom_range(30000, 200000),
                       $urandom_range(2047), $urandom_range(2047),
                       $urandom_range(1, 8192), $urandom_range(1, 8192),
                       $urandom_range(8191), $urandom_range(8191));
         run_cells(150);
      end
   endtask

   // The receiver holds off while two passing cells are offered back to back.
   task automatic test_output_backpressure();
      apply_setting(0, 65536, 0, 0, 640, 640, 0, 0);
      req_gap_pct   = 0;
      rsp_hold_left = 300;
      repeat (2) begin
         send_header(rand_grid(), rand_grid(), 2'($urandom_range(3)), 16'h0000,
                     rand_q88(), rand_q88(), rand_q88(), rand_q88());
         repeat (pose_dec_pkg::NUM_KPTS) send_keypoint(rand_q88(), rand_q88(), rand_q88());
      end
      req_gap_pct = 20;
   endtask

   // The sender stops in the middle of a cell until every result is out, then goes on.
   task automatic test_input_pause();
      send_header(rand_grid(), rand_grid(), 2'($urandom_range(3)), 16'h0100,
                  rand_q88(), rand_q88(), rand_q88(), rand_q88());
      repeat (8) send_keypoint(rand_q88(), rand_q88(), rand_q88());
      drain_results();
      repeat (pose_dec_pkg::NUM_KPTS - 8) send_keypoint(rand_q88(), rand_q88(), rand_q88());
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_output_backpressure();
      test_input_pause();
      drain_results();
      if (mismatches == 0) begin
         $display("[pose_anchor_decoder_top] OK");
      end else begin
         $display("[pose_anchor_decoder_top] ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[pose_anchor_decoder_top] ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/core/pose_dec_pkg.sv
rtl/core/pose_anchor_decoder_top.sv
test/tb.sv
